FILE: rtl/atws_pkg.sv
// atws_pkg: shared types, constants and micro-op codes of the arctangent waveshaper
`timescale 1ns / 1ps
package atws_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_COEF_POS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_NEG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STAGES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_MASK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd4;

	// Q.20 internal arithmetic constants
	localparam logic [20:0] K_PI4 = 21'd823550;
	localparam logic [17:0] K_A = 18'd256587;
	localparam logic [16:0] K_B = 17'd69521;
	localparam logic [20:0] K_ONE = 21'd1048576;

	// divider: 26 quotient bits, clamped to 2^23 when the stage value is formed
	localparam int QUOT_W = 26;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic block_end;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic block_end_out;
	} result_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CX,
		OP_CQ,
		OP_F1,
		OP_F2,
		OP_F3,
		OP_F4,
		OP_F5,
		OP_F6,
		OP_F7D,
		OP_F7N,
		OP_DINIT,
		OP_DSTEP,
		OP_SEND,
		OP_GAIN,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
		logic neg;
	} cmd_t;

endpackage

FILE: rtl/atws_datapath.sv
// atws_datapath: shared multiplier, bit-serial divider and working registers
`timescale 1ns / 1ps
module atws_datapath (
	input logic clk,
	input atws_pkg::cmd_t cmd,
	input atws_pkg::sample_t sample_data,
	input logic [15:0] pos_coef,
	input logic [15:0] neg_coef,
	input logic [15:0] gain,
	output atws_pkg::result_t result_data
);

	localparam int SB = atws_pkg::SAMPLE_BITS;
	localparam int SHR = (SB > 24) ? SB - 24 : 0;
	localparam int SHL = (SB < 24) ? 24 - SB : 0;
	localparam int M_W = 30;
	localparam int P_W = 60;
	localparam int V_W = 29;
	localparam int T1_W = 30;
	localparam int Q_W = 26;
	localparam int R_W = 38;
	localparam int FA_W = 42;
	localparam int REM_W = FA_W + 20;
	localparam int DSH_W = FA_W + 25;
	localparam int QW = atws_pkg::QUOT_W;
	localparam logic signed [47:0] SMAX = (48'sd1 <<< (SB - 1)) - 48'sd1;
	localparam logic signed [47:0] SMIN = -(48'sd1 <<< (SB - 1));

	logic signed [23:0] x_q;
	logic be_q;
	logic signed [V_W-1:0] v_q, u_q;
	logic signed [P_W-1:0] prod_q;
	logic signed [T1_W-1:0] t1_q;
	logic signed [Q_W-1:0] q_q;
	logic signed [R_W-1:0] r_q;
	logic signed [63:0] acc_q;
	logic signed [FA_W-1:0] den_q, num_q;
	logic [REM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QW-1:0] quot_q;
	atws_pkg::result_t result_q;

	logic [15:0] coef;
	logic [V_W-1:0] v_abs;
	logic signed [M_W-1:0] mul_a, mul_b;
	logic signed [39:0] s_ext, s_conv;
	logic signed [23:0] x_load;
	logic signed [63:0] fa_full;
	logic [FA_W-1:0] num_abs, den_abs;
	logic div_ge;
	logic [QW-1:0] mq;
	logic signed [25:0] y_raw, y_neg;
	logic signed [23:0] y_sat;
	logic signed [47:0] z_ext, z_conv;
	logic signed [SB-1:0] z_sat;

	assign coef = x_q[23] ? neg_coef : pos_coef;
	assign v_abs = v_q[V_W-1] ? V_W'(-v_q) : V_W'(v_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			atws_pkg::OP_CX: begin
				mul_a = M_W'($signed({1'b0, coef}));
				mul_b = M_W'(x_q);
			end
			atws_pkg::OP_F1: begin
				mul_a = M_W'($signed({1'b0, atws_pkg::K_PI4}));
				mul_b = M_W'(v_q);
			end
			atws_pkg::OP_F2: begin
				mul_a = M_W'($signed({1'b0, atws_pkg::K_B}));
				mul_b = M_W'($signed({1'b0, v_abs}));
			end
			atws_pkg::OP_F3: begin
				mul_a = M_W'(v_q);
				mul_b = M_W'($signed({1'b0, v_abs})) - M_W'($signed({1'b0, atws_pkg::K_ONE}));
			end
			atws_pkg::OP_F5: begin
				mul_a = M_W'(r_q >>> 18);
				mul_b = M_W'(q_q);
			end
			atws_pkg::OP_F6: begin
				mul_a = M_W'($signed({1'b0, r_q[17:0]}));
				mul_b = M_W'(q_q);
			end
			atws_pkg::OP_GAIN: begin
				mul_a = M_W'(x_q);
				mul_b = M_W'($signed({1'b0, gain}));
			end
			default: begin
			end
		endcase
	end

	// sample format to Q.20, floor on dropped bits, then clamp to the inner range
	always_comb begin
		s_ext = 40'(sample_data.sample_in);
		s_conv = (s_ext <<< SHL) >>> SHR;
		if (s_conv > 40'sd8388607)
			x_load = 24'sh7FFFFF;
		else if (s_conv < -40'sd8388608)
			x_load = 24'sh800000;
		else
			x_load = s_conv[23:0];
	end

	assign fa_full = 64'(t1_q) - ((acc_q + 64'(prod_q)) >>> 20);
	assign num_abs = num_q[FA_W-1] ? FA_W'(-num_q) : FA_W'(num_q);
	assign den_abs = den_q[FA_W-1] ? FA_W'(-den_q) : FA_W'(den_q);
	assign div_ge = {{(DSH_W-REM_W){1'b0}}, rem_q} >= dsh_q;

	// stage value from quotient, with zero denominator saturating by sign
	always_comb begin
		mq = (quot_q > QW'(24'd8388608)) ? QW'(24'd8388608) : quot_q;
		if (den_q == '0) begin
			if (num_q > 0)
				y_raw = 26'sd8388607;
			else if (num_q < 0)
				y_raw = -26'sd8388608;
			else
				y_raw = '0;
		end else if (num_q[FA_W-1] ^ den_q[FA_W-1]) begin
			y_raw = -$signed(mq);
		end else begin
			y_raw = $signed(mq);
		end
		y_neg = cmd.neg ? -y_raw : y_raw;
		if (y_neg > 26'sd8388607)
			y_sat = 24'sh7FFFFF;
		else if (y_neg < -26'sd8388608)
			y_sat = 24'sh800000;
		else
			y_sat = y_neg[23:0];
	end

	// gain result back to the sample format, saturated
	always_comb begin
		z_ext = 48'(prod_q >>> 12);
		z_conv = (z_ext <<< SHR) >>> SHL;
		if (z_conv > SMAX)
			z_sat = SB'(SMAX);
		else if (z_conv < SMIN)
			z_sat = SB'(SMIN);
		else
			z_sat = z_conv[SB-1:0];
	end

	always_ff @(posedge clk) begin
		prod_q <= P_W'(mul_a * mul_b);
		case (cmd.op)
			atws_pkg::OP_LOAD: begin
				x_q <= x_load;
				be_q <= sample_data.block_end;
			end
			atws_pkg::OP_CQ: begin
				v_q <= V_W'($signed({1'b0, coef, 8'b0}));
				u_q <= V_W'(prod_q >>> 12);
			end
			atws_pkg::OP_F2: t1_q <= T1_W'(prod_q >>> 20);
			atws_pkg::OP_F3: q_q <= Q_W'(prod_q >>> 20) + Q_W'(atws_pkg::K_A);
			atws_pkg::OP_F4: r_q <= R_W'(prod_q >>> 20);
			atws_pkg::OP_F6: acc_q <= 64'(prod_q) <<< 18;
			atws_pkg::OP_F7D: begin
				den_q <= FA_W'(fa_full);
				v_q <= u_q;
			end
			atws_pkg::OP_F7N: num_q <= FA_W'(fa_full);
			atws_pkg::OP_DINIT: begin
				rem_q <= {num_abs, 20'b0};
				dsh_q <= {den_abs, 25'b0};
				quot_q <= '0;
			end
			atws_pkg::OP_DSTEP: begin
				if (div_ge)
					rem_q <= rem_q - dsh_q[REM_W-1:0];
				quot_q <= {quot_q[QW-2:0], div_ge};
				dsh_q <= dsh_q >> 1;
			end
			atws_pkg::OP_SEND: x_q <= y_sat;
			atws_pkg::OP_OUT: begin
				result_q.sample_out <= z_sat;
				result_q.block_end_out <= be_q;
			end
			default: begin
			end
		endcase
	end

	assign result_data = result_q;

endmodule

FILE: rtl/atws_ctrl.sv
// atws_ctrl: sequencer that steps the datapath through stages, divide and gain
`timescale 1ns / 1ps
module atws_ctrl #(
	parameter int STG_W = 4
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	output logic result_valid,
	input logic result_stall,
	input logic [STG_W-1:0] stage_lim,
	input logic [2:0] inv_mask,
	output atws_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CX,
		ST_CQ,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_F4,
		ST_F5,
		ST_F6,
		ST_F7,
		ST_DINIT,
		ST_DSTEP,
		ST_SEND,
		ST_GAIN,
		ST_OUT
	} state_t;

	state_t state_q;
	logic pass_q;
	logic [STG_W-1:0] stage_q;
	logic [4:0] div_cnt_q;
	logic out_valid_q;
	logic slot_free;
	logic [STG_W+2:0] stage_ext;

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign slot_free = !out_valid_q || !result_stall;
	assign stage_ext = {3'b000, stage_q};

	always_comb begin
		cmd.neg = |(inv_mask & stage_ext[2:0]);
		case (state_q)
			ST_IDLE: cmd.op = sample_valid ? atws_pkg::OP_LOAD : atws_pkg::OP_NONE;
			ST_CX: cmd.op = atws_pkg::OP_CX;
			ST_CQ: cmd.op = atws_pkg::OP_CQ;
			ST_F1: cmd.op = atws_pkg::OP_F1;
			ST_F2: cmd.op = atws_pkg::OP_F2;
			ST_F3: cmd.op = atws_pkg::OP_F3;
			ST_F4: cmd.op = atws_pkg::OP_F4;
			ST_F5: cmd.op = atws_pkg::OP_F5;
			ST_F6: cmd.op = atws_pkg::OP_F6;
			ST_F7: cmd.op = pass_q ? atws_pkg::OP_F7N : atws_pkg::OP_F7D;
			ST_DINIT: cmd.op = atws_pkg::OP_DINIT;
			ST_DSTEP: cmd.op = atws_pkg::OP_DSTEP;
			ST_SEND: cmd.op = atws_pkg::OP_SEND;
			ST_GAIN: cmd.op = atws_pkg::OP_GAIN;
			// keep the gain product live while the output register is held
			ST_OUT: cmd.op = slot_free ? atws_pkg::OP_OUT : atws_pkg::OP_GAIN;
			default: cmd.op = atws_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= 1'b0;
			stage_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register fills when leaving the output state, empties on transfer
			if (state_q == ST_OUT && slot_free)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						stage_q <= '0;
						pass_q <= 1'b0;
						state_q <= (stage_lim == '0) ? ST_GAIN : ST_CX;
					end
				end
				ST_CX: state_q <= ST_CQ;
				ST_CQ: state_q <= ST_F1;
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: state_q <= ST_F4;
				ST_F4: state_q <= ST_F5;
				ST_F5: state_q <= ST_F6;
				ST_F6: state_q <= ST_F7;
				ST_F7: begin
					// first pass gives the denominator, second the numerator
					pass_q <= !pass_q;
					state_q <= pass_q ? ST_DINIT : ST_F1;
				end
				ST_DINIT: begin
					div_cnt_q <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					if (div_cnt_q == 5'(atws_pkg::QUOT_W - 1)) begin
						div_cnt_q <= '0;
						state_q <= ST_SEND;
					end else begin
						div_cnt_q <= div_cnt_q + 5'd1;
					end
				end
				ST_SEND: begin
					stage_q <= stage_q + 1'b1;
					state_q <= (stage_q + 1'b1 == stage_lim) ? ST_GAIN : ST_CX;
				end
				ST_GAIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_div_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DSTEP) |-> (div_cnt_q == '0))
		else $error("divider count active outside divide steps");
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result valid raised outside output state");
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> (state_q != ST_IDLE))
		else $error("sequencer idle right after sample transfer");
`endif

endmodule

FILE: rtl/atan_waveshaper_top.sv
// atan_waveshaper_top: configuration registers and the sequencer/datapath pair
`timescale 1ns / 1ps
// Arctangent waveshaper: one sample in, one shaped sample out. Each sample
// runs through min(stage_count, MAX_STAGES) shaping stages, then the output
// gain with saturation. Every stage runs two arctangent evaluations on the
// shared 30x30 multiplier, then the one-bit-per-cycle divider. A new sample
// is taken as soon as the previous one has reached the output register.
module atan_waveshaper_top #(
	parameter int MAX_STAGES = 8
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input atws_pkg::sample_t sample_data,
	output logic result_valid,
	input logic result_stall,
	output atws_pkg::result_t result_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [atws_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [atws_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int STG_W = $clog2(MAX_STAGES + 1);

	logic [15:0] pos_coef_q, neg_coef_q, gain_q;
	logic [3:0] stages_q;
	logic [2:0] inv_mask_q;
	logic [STG_W-1:0] stage_lim;
	atws_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_coef_q <= 16'd4096;
			neg_coef_q <= 16'd4096;
			stages_q <= 4'd1;
			inv_mask_q <= 3'd0;
			gain_q <= 16'd4096;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				atws_pkg::REG_COEF_POS: pos_coef_q <= cfg_data;
				atws_pkg::REG_COEF_NEG: neg_coef_q <= cfg_data;
				atws_pkg::REG_STAGES: stages_q <= cfg_data[3:0];
				atws_pkg::REG_INV_MASK: inv_mask_q <= cfg_data[2:0];
				atws_pkg::REG_GAIN: gain_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign stage_lim = ({1'b0, stages_q} > 5'(MAX_STAGES)) ? STG_W'(MAX_STAGES)
		: STG_W'(stages_q);

	atws_ctrl #(
		.STG_W(STG_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.stage_lim(stage_lim),
		.inv_mask(inv_mask_q),
		.cmd(cmd)
	);

	atws_datapath u_datapath (
		.clk(clk),
		.cmd(cmd),
		.sample_data(sample_data),
		.pos_coef(pos_coef_q),
		.neg_coef(neg_coef_q),
		.gain(gain_q),
		.result_data(result_data)
	);

endmodule
